[src/seaweed_suffix_prefix_lcs_defines.svh]
// Assertion macros for the seaweed suffix-prefix LCS checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SEAWEED_SUFFIX_PREFIX_LCS_DEFINES_SVH
`define SEAWEED_SUFFIX_PREFIX_LCS_DEFINES_SVH

// same-cycle implication
`define SSPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sspl assertion failed");

// next-cycle implication
`define SSPL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sspl assertion failed");

`endif

[src/sspl_pkg.sv]
// Shared types and constants of the seaweed suffix-prefix LCS block.
// No dependencies.
package sspl_pkg;

    localparam int SYM_IN_W = 8;
    localparam int A_POS_W  = 6;
    localparam int B_POS_W  = 10;
    localparam int LCS_W    = 11;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    typedef struct packed {
        logic start_job;
        logic count_en;
    } t_cell_ctl;

endpackage

[src/sspl_intf.sv]
// Request channel interfaces of the seaweed suffix-prefix LCS block.
// Depends on sspl_pkg.
interface sspl_in_if;
    import sspl_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [SYM_IN_W-1:0] symbol;
    logic                final_symbol;

    modport source (output valid, output cmd, output symbol, output final_symbol,
                    input ready);
    modport sink   (input valid, input cmd, input symbol, input final_symbol,
                    output ready);
endinterface

interface sspl_out_if;
    import sspl_pkg::*;

    logic               valid;
    logic               ready;
    logic [A_POS_W-1:0] a_pos;
    logic [B_POS_W-1:0] b_pos;
    logic [LCS_W-1:0]   lcs_value;
    logic               column_end;

    modport source (output valid, output a_pos, output b_pos, output lcs_value,
                    output column_end, input ready);
    modport sink   (input valid, input a_pos, input b_pos, input lcs_value,
                    input column_end, output ready);
endinterface

[src/seaweed_suffix_prefix_lcs.sv]
// Flow: a B symbol passes the cell chain through one token register per cell, then the
// counters update, then one result per cycle while the output is not stalled, for the
// A_len positions. No new symbol is taken until the last result is out, so the B rate
// is set by the chain depth and the single output port; A symbols load back to back.
// Reset: synchronous active low; loading phase, empty A, seaweed values index+1.
module seaweed_suffix_prefix_lcs #(
    parameter int MAX_A_LEN   = 32,
    parameter int MAX_B_LEN   = 1024,
    parameter int SYMBOL_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sspl_in_if.sink   i_in,
    sspl_out_if.source o_out
);
    import sspl_pkg::*;

    localparam int VW = $clog2(MAX_A_LEN + 1);
    localparam int IW = (MAX_A_LEN > 1) ? $clog2(MAX_A_LEN) : 1;
    localparam int CW = $clog2(MAX_B_LEN + 1);
    localparam int BW = (MAX_B_LEN > 1) ? $clog2(MAX_B_LEN) : 1;
    localparam int SW = (SYMBOL_BITS < SYM_IN_W) ? SYMBOL_BITS : SYM_IN_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic          r_sweeping, n_sweeping;
    logic [VW-1:0] r_a_len, n_a_len;
    logic [BW-1:0] r_b_count, n_b_count;
    logic          r_fin, n_fin;
    logic [IW-1:0] r_emit_idx, n_emit_idx;
    logic          r_out_vld, n_out_vld;

    logic [A_POS_W-1:0] r_a_pos;
    logic [B_POS_W-1:0] r_b_pos;
    logic [LCS_W-1:0]   r_lcs;
    logic               r_col_end;

    logic          in_acc, ld, ld_wr, ld_start, sw;
    logic          out_free, emit_now, emit_last, job_end;
    t_cell_ctl     ctl;

    logic          tok_vld [MAX_A_LEN+1];
    logic [VW-1:0] tok_x   [MAX_A_LEN+1];
    logic [SW-1:0] tok_sym [MAX_A_LEN+1];
    logic [CW-1:0] w_count [MAX_A_LEN];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign ld         = in_acc && (i_in.cmd == CMD_LOAD) && !r_sweeping;
    assign sw         = in_acc && (i_in.cmd == CMD_SWEEP) && r_sweeping;
    assign ld_wr      = ld && (r_a_len < VW'(MAX_A_LEN));
    assign ld_start   = ld && i_in.final_symbol;

    assign ctl.start_job = ld_start;
    assign ctl.count_en  = (r_state == S_SWEEP) && tok_vld[MAX_A_LEN];

    assign out_free  = !r_out_vld || o_out.ready;
    assign emit_now  = (r_state == S_EMIT) && out_free;
    assign emit_last = (VW'(r_emit_idx) + VW'(1)) == r_a_len;
    assign job_end   = r_fin || (r_b_count == BW'(MAX_B_LEN - 1));

    assign tok_vld[0] = sw;
    assign tok_x[0]   = '0;
    assign tok_sym[0] = i_in.symbol[SW-1:0];

    for (genvar k = 0; k < MAX_A_LEN; k++) begin : g_cell
        sspl_cell #(
            .IDX       (k),
            .VW        (VW),
            .CW        (CW),
            .SW        (SW),
            .MAX_B_LEN (MAX_B_LEN)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_load     (ld_wr && (r_a_len == VW'(k))),
            .i_load_sym (i_in.symbol[SW-1:0]),
            .i_active   (VW'(k) < r_a_len),
            .i_tok_vld  (tok_vld[k]),
            .i_tok_x    (tok_x[k]),
            .i_tok_sym  (tok_sym[k]),
            .i_exit     (tok_x[MAX_A_LEN]),
            .o_tok_vld  (tok_vld[k+1]),
            .o_tok_x    (tok_x[k+1]),
            .o_tok_sym  (tok_sym[k+1]),
            .o_count    (w_count[k])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_sweeping = r_sweeping;
        n_a_len    = r_a_len;
        n_b_count  = r_b_count;
        n_fin      = r_fin;
        n_emit_idx = r_emit_idx;
        n_out_vld  = r_out_vld;
        if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (ld_wr) begin
                    n_a_len = r_a_len + VW'(1);
                end
                if (ld_start) begin
                    n_sweeping = 1'b1;
                end
                if (sw) begin
                    n_fin   = i_in.final_symbol;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (ctl.count_en) begin
                    n_emit_idx = '0;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_now) begin
                    n_out_vld  = 1'b1;
                    n_emit_idx = r_emit_idx + IW'(1);
                    if (emit_last) begin
                        n_state = S_IDLE;
                        if (job_end) begin
                            n_sweeping = 1'b0;
                            n_a_len    = '0;
                            n_b_count  = '0;
                        end else begin
                            n_b_count = r_b_count + BW'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sweeping <= 1'b0;
            r_a_len    <= '0;
            r_b_count  <= '0;
            r_fin      <= 1'b0;
            r_emit_idx <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sweeping <= n_sweeping;
            r_a_len    <= n_a_len;
            r_b_count  <= n_b_count;
            r_fin      <= n_fin;
            r_emit_idx <= n_emit_idx;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_a_pos   <= A_POS_W'(r_emit_idx);
            r_b_pos   <= B_POS_W'(r_b_count);
            r_lcs     <= LCS_W'(w_count[r_emit_idx]);
            r_col_end <= emit_last;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.a_pos      = r_a_pos;
    assign o_out.b_pos      = r_b_pos;
    assign o_out.lcs_value  = r_lcs;
    assign o_out.column_end = r_col_end;

endmodule

[src/sspl_cell.sv]
// One A position: stored symbol, seaweed value and exit counter.
// Depends on sspl_pkg; chained by seaweed_suffix_prefix_lcs.
module sspl_cell #(
    parameter int IDX         = 0,
    parameter int VW          = 6,
    parameter int CW          = 11,
    parameter int SW          = 8,
    parameter int MAX_B_LEN   = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sspl_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_load,
    input  logic [SW-1:0]        i_load_sym,
    input  logic                 i_active,
    input  logic                 i_tok_vld,
    input  logic [VW-1:0]        i_tok_x,
    input  logic [SW-1:0]        i_tok_sym,
    input  logic [VW-1:0]        i_exit,
    output logic                 o_tok_vld,
    output logic [VW-1:0]        o_tok_x,
    output logic [SW-1:0]        o_tok_sym,
    output logic [CW-1:0]        o_count
);
    import sspl_pkg::*;

    logic [SW-1:0] r_sym;
    logic [VW-1:0] r_val, n_val;
    logic [CW-1:0] r_count, n_count;
    logic          r_tok_vld;
    logic [VW-1:0] r_tok_x, n_tok_x;
    logic [SW-1:0] r_tok_sym;
    logic          swap;

    assign swap = i_tok_vld && i_active && ((i_tok_x >= r_val) || (i_tok_sym == r_sym));

    always_comb begin
        n_val   = r_val;
        n_count = r_count;
        n_tok_x = i_tok_x;
        if (swap) begin
            n_val   = i_tok_x;
            n_tok_x = r_val;
        end
        if (i_ctl.count_en && i_active && (VW'(IDX) < i_exit)
            && (r_count < CW'(MAX_B_LEN))) begin
            n_count = r_count + CW'(1);
        end
        if (i_ctl.start_job) begin
            n_val   = VW'(IDX + 1);
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val     <= VW'(IDX + 1);
            r_count   <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_val     <= n_val;
            r_count   <= n_count;
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sym <= i_load_sym;
        end
        r_tok_x   <= n_tok_x;
        r_tok_sym <= i_tok_sym;
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok_x   = r_tok_x;
    assign o_tok_sym = r_tok_sym;
    assign o_count   = r_count;

endmodule

[src/sspl_checker.sv]
// Port-level checks of the seaweed suffix-prefix LCS block, bound to its top level.
// Depends on sspl_pkg and seaweed_suffix_prefix_lcs_defines.svh.
`include "seaweed_suffix_prefix_lcs_defines.svh"

module sspl_checker #(
    parameter int MAX_A_LEN = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [sspl_pkg::A_POS_W-1:0] i_a_pos,
    input logic [sspl_pkg::B_POS_W-1:0] i_b_pos,
    input logic [sspl_pkg::LCS_W-1:0]   i_lcs_value,
    input logic                         i_column_end
);
    import sspl_pkg::*;

    logic stall;
    assign stall = i_out_valid && !i_out_ready;

    `SSPL_ASSERT_NXT(a_out_hold, stall, i_out_valid)
    `SSPL_ASSERT_NXT(a_out_stable, stall, $stable(i_a_pos) && $stable(i_lcs_value) && $stable(i_column_end))
    `SSPL_ASSERT_IMP(a_lcs_bound, i_out_valid, {1'b0, i_lcs_value} <= ({2'b0, i_b_pos} + 12'd1))
    `SSPL_ASSERT_IMP(a_last_pos_ends, i_out_valid && (i_a_pos == A_POS_W'(MAX_A_LEN - 1)), i_column_end)

endmodule

bind seaweed_suffix_prefix_lcs sspl_checker #(
    .MAX_A_LEN (MAX_A_LEN)
) u_sspl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_a_pos      (o_out.a_pos),
    .i_b_pos      (o_out.b_pos),
    .i_lcs_value  (o_out.lcs_value),
    .i_column_end (o_out.column_end)
);
